// File: design/uvd_pkg.sv
// ----------------------------------------------------------------------------
// uvd_pkg
// Shared constants, types and the hash fold step for the url visit dedup table.
// ----------------------------------------------------------------------------
package uvd_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
   // prime is 2^40 + 0x1b3
   localparam int          FNV_HI_SHIFT = 40;
   localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;

   typedef struct packed {
      logic        vld;
      logic [63:0] hash;
   } hash_item_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] count;
   } back_status_type;

   function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] lo;
      logic [63:0] prod;
      lo   = h * FNV_PRIME_LO;
      prod = (h << FNV_HI_SHIFT) + lo;
      return prod ^ {56'b0, b};
   endfunction

endpackage

// File: design/uvd_front.sv
// ----------------------------------------------------------------------------
// uvd_front
// Folds url bytes into the running hash and pushes finished hashes to the queue.
// ----------------------------------------------------------------------------
module uvd_front
   import uvd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_url_byte,
   input  logic          req_last,
   input  logic          q_full,
   output hash_item_type q_push
);

   logic [63:0] hash_ff, hash_in;
   logic        term_ff, term_in;
   logic [63:0] folded;
   logic        accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      folded = hash_ff;
      if (!term_ff && (req_url_byte != 8'd0)) begin
         folded = fnv_fold(hash_ff, req_url_byte);
      end
   end

   always_comb begin
      hash_in     = hash_ff;
      term_in     = term_ff;
      q_push.vld  = 1'b0;
      q_push.hash = folded;
      if (accept) begin
         if (req_last) begin
            // url done: hand over the hash and start afresh
            q_push.vld = 1'b1;
            hash_in    = FNV_BASIS;
            term_in    = 1'b0;
         end else begin
            hash_in = folded;
            term_in = term_ff || (req_url_byte == 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         term_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         term_ff <= term_in;
      end
   end

endmodule

// File: design/uvd_queue.sv
// ----------------------------------------------------------------------------
// uvd_queue
// Two-entry queue of finished hashes between the front and the table search.
// ----------------------------------------------------------------------------
module uvd_queue
   import uvd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  hash_item_type q_push,
   output logic          q_full,
   output hash_item_type q_head,
   input  logic          q_pop
);

   logic [63:0] slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   assign q_full      = (cnt_ff == 2'd2);
   assign q_head.vld  = (cnt_ff != 2'd0);
   assign q_head.hash = slot_ff[rd_ptr_ff];
   assign do_push     = q_push.vld && !q_full;
   assign do_pop      = q_pop && q_head.vld;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: design/uvd_back.sv
// ----------------------------------------------------------------------------
// uvd_back
// Walks the table for each hash, records it if new and room is left, reports.
// ----------------------------------------------------------------------------
module uvd_back
   import uvd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  hash_item_type   q_head,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_seen,
   output logic            rsp_stored,
   output logic            rsp_overflow,
   output back_status_type stat
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic [63:0]      table_mem [TABLE_DEPTH];

   logic             state_ff, state_in;
   logic [63:0]      key_ff, key_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [63:0]      rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             seen_ff, seen_in;
   logic             stored_ff, stored_in;
   logic             overflow_ff, overflow_in;
   logic             rd_en, mem_we;
   logic             hit, miss, slot_free, has_room;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign hit       = rd_vld_ff && (rd_data_ff == key_ff);
   // nothing in flight and every live entry compared
   assign miss      = !rd_vld_ff && (issue_ff >= count_ff);
   assign has_room  = (count_ff < CNT_W'(TABLE_DEPTH));

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_vld_in    = rd_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      seen_in      = seen_ff;
      stored_in    = stored_ff;
      overflow_in  = overflow_ff;
      rd_en        = 1'b0;
      mem_we       = 1'b0;
      q_pop        = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_head.vld) begin
               q_pop     = 1'b1;
               key_in    = q_head.hash;
               issue_in  = '0;
               rd_vld_in = 1'b0;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit || miss) begin
               // hold here until the result register can take the item
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  seen_in      = hit;
                  stored_in    = !hit && has_room;
                  overflow_in  = !hit && !has_room;
                  rd_vld_in    = 1'b0;
                  state_in     = ST_IDLE;
                  if (!hit && has_room) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end else if (issue_ff < count_ff) begin
               rd_en     = 1'b1;
               issue_in  = issue_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
            end else begin
               rd_vld_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[count_ff[ADDR_W-1:0]] <= key_ff;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[issue_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      issue_ff    <= issue_in;
      seen_ff     <= seen_in;
      stored_ff   <= stored_in;
      overflow_ff <= overflow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_seen     = seen_ff;
   assign rsp_stored   = stored_ff;
   assign rsp_overflow = overflow_ff;
   assign stat.busy    = (state_ff == ST_SEARCH);
   assign stat.count   = count_ff;

endmodule

// File: design/url_visit_dedup_table_core.sv
// ----------------------------------------------------------------------------
// url_visit_dedup_table_core
// Hashes urls byte by byte and tests each finished hash against a visit table.
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one url byte per item; req_last marks the final byte of a url.
//   bytes fold into a 64-bit fnv-1 hash, one item per cycle with req_ready high;
//   a zero byte ends hashing, later bytes up to req_last are taken but ignored.
//   each url gives one rsp_* item with exactly one of seen, stored, overflow set.
//   the final hash waits in a two-entry queue while the table walk runs, so
//   bytes of the next url keep flowing.
//   after the last byte the hash passes the queue and the table walk to rsp_valid;
//   the walk reads one table entry per cycle from the single-port table ram, so
//   the longer of the byte stream and the walk sets the sustained url rate.
//   reset empties the table (entry count to zero) and restarts the hash at once,
//   no clearing pass is needed.
//   a stalled rsp_ready holds the result; the walk then waits, the queue fills
//   and req_ready falls once two finished hashes wait in the queue.
// ----------------------------------------------------------------------------
module url_visit_dedup_table_core
   import uvd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_url_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_seen,
   output logic       rsp_stored,
   output logic       rsp_overflow
);

   hash_item_type   q_push;
   hash_item_type   q_head;
   logic            q_full;
   logic            q_pop;
   back_status_type stat;

   uvd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_url_byte (req_url_byte),
      .req_last     (req_last),
      .q_full       (q_full),
      .q_push       (q_push)
   );

   uvd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   uvd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_seen     (rsp_seen),
      .rsp_stored   (rsp_stored),
      .rsp_overflow (rsp_overflow),
      .stat         (stat)
   );

`ifndef SYNTHESIS
   a_rsp_onehot : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_seen, rsp_stored, rsp_overflow}))
      else $error("result item without exactly one outcome flag");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      stat.count <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (stat.count != $past(stat.count)))
      |-> ((stat.count == $past(stat.count) + CNT_W'(1)) && rsp_valid && rsp_stored))
      else $error("entry count moved without a stored result");

   a_pop_idle : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_head.vld && !stat.busy))
      else $error("queue popped while a walk is in progress");
`endif

endmodule

// File: verif/url_visit_dedup_table_core_tb.sv
// ----------------------------------------------------------------------------
// url_visit_dedup_table_core_tb
// Streams url bytes into the dedup table and checks every seen, stored and
// overflow verdict against a local fnv-1 hash set or a typed verdict. Directed
// rows first, then random urls and revisits under four handshake idling mixes.
// ----------------------------------------------------------------------------
module url_visit_dedup_table_core_tb
   import uvd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] HASH_PRIME = 64'h0000_0100_0000_01b3;
   localparam int          MAX_URL    = 16;
   localparam int          N_DIRECTED = 22;

   typedef struct packed {
      logic seen;
      logic stored;
      logic overflow;
   } verdict_type;

   typedef struct packed {
      logic [4:0]               len;
      logic [MAX_URL-1:0][7:0] text;
   } url_type;

   typedef struct packed {
      logic [7:0]  url_byte;
      logic        last;
      logic        typed;
      verdict_type verdict;
   } directed_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_url_byte;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_seen;
   logic       rsp_stored;
   logic       rsp_overflow;

   // local copy of the hash set
   logic [63:0] hash_acc;
   bit          hash_done;
   logic [63:0] hash_log [TABLE_DEPTH];
   int          log_count;

   verdict_type pending_verdicts [$];
   url_type     url_history [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count   = 0;
   int byte_items    = 0;
   int url_items     = 0;
   int seen_count    = 0;
   int stored_count  = 0;
   int overflow_count = 0;

   // typed verdicts only where they follow from reset or an exact repeat
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{8'h00, 1'b1, 1'b1, 3'b010},  // empty url, table empty after reset
      '{8'h00, 1'b1, 1'b1, 3'b100},  // same empty url again
      '{8'hff, 1'b1, 1'b1, 3'b010},
      '{8'hff, 1'b1, 1'b1, 3'b100},
      '{8'h01, 1'b1, 1'b0, 3'b000},
      '{8'h61, 1'b0, 1'b0, 3'b000},  // bytes after the zero are ignored
      '{8'h00, 1'b0, 1'b0, 3'b000},
      '{8'h62, 1'b0, 1'b0, 3'b000},
      '{8'h63, 1'b1, 1'b0, 3'b000},
      '{8'h61, 1'b1, 1'b1, 3'b100},  // same hash as the url above
      '{8'h61, 1'b0, 1'b0, 3'b000},  // zero on the final byte ends hashing
      '{8'h62, 1'b0, 1'b0, 3'b000},
      '{8'h00, 1'b1, 1'b0, 3'b000},
      '{8'h61, 1'b0, 1'b0, 3'b000},
      '{8'h62, 1'b1, 1'b1, 3'b100},
      '{8'h80, 1'b0, 1'b0, 3'b000},
      '{8'h7f, 1'b1, 1'b0, 3'b000},
      '{8'h55, 1'b0, 1'b0, 3'b000},
      '{8'haa, 1'b1, 1'b0, 3'b000},
      '{8'h00, 1'b0, 1'b0, 3'b000},  // leading zero, rest is garbage
      '{8'hff, 1'b0, 1'b0, 3'b000},
      '{8'h01, 1'b1, 1'b1, 3'b100}
   };

   url_visit_dedup_table_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_url_byte (req_url_byte),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_seen     (rsp_seen),
      .rsp_stored   (rsp_stored),
      .rsp_overflow (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // fold one byte; on the final byte test-and-insert the finished hash
   task automatic hash_and_lookup(input logic [7:0] b, input logic l,
                                  output bit has_verdict, output verdict_type v);
      bit hit;
      hit         = 1'b0;
      v           = '0;
      has_verdict = 1'b0;
      if (!hash_done) begin
         if (b == 8'h00) begin
            hash_done = 1'b1;
         end else begin
            hash_acc = (hash_acc * HASH_PRIME) ^ {56'h0, b};
         end
      end
      if (l) begin
         for (int i = 0; i < log_count; i++) begin
            if (hash_log[i] == hash_acc) hit = 1'b1;
         end
         if (hit) begin
            v.seen = 1'b1;
         end else if (log_count < TABLE_DEPTH) begin
            hash_log[log_count] = hash_acc;
            log_count++;
            v.stored = 1'b1;
         end else begin
            v.overflow = 1'b1;
         end
         hash_acc    = FNV_BASIS;
         hash_done   = 1'b0;
         has_verdict = 1'b1;
      end
   endtask

   task automatic drive_item(input logic [7:0] b, input logic l,
                             input bit typed, input verdict_type typed_v);
      bit          has_verdict;
      verdict_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_url_byte <= b;
      req_last     <= l;
      do @(posedge clock); while (!req_ready);
      byte_items++;
      hash_and_lookup(b, l, has_verdict, v);
      if (has_verdict) begin
         pending_verdicts.push_back(typed ? typed_v : v);
         url_items++;
      end
   endtask

   task automatic send_url(input url_type u);
      for (int i = 0; i < u.len; i++) begin
         drive_item(u.text[i], i == u.len - 1, 1'b0, '0);
      end
      url_history.push_back(u);
   endtask

   function automatic url_type random_url(input int max_len);
      url_type u;
      u     = '0;
      u.len = $urandom_range(max_len, 1);
      for (int i = 0; i < u.len; i++) u.text[i] = $urandom_range(255, 1);
      case ($urandom_range(9))
         0: u.text[$urandom_range(u.len - 1)] = 8'h00;
         1: u.text[u.len - 1] = 8'h00;
         default: ;
      endcase
      return u;
   endfunction

   function automatic url_type old_url();
      return url_history[$urandom_range(url_history.size() - 1)];
   endfunction

   // result side: random stalls, compare against the oldest verdict
   initial begin
      verdict_type want;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               $error("unexpected result: seen=%0b stored=%0b overflow=%0b",
                      rsp_seen, rsp_stored, rsp_overflow);
               error_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_seen !== want.seen) begin
                  $error("rsp_seen: expected %0b, got %0b", want.seen, rsp_seen);
                  error_count++;
               end
               if (rsp_stored !== want.stored) begin
                  $error("rsp_stored: expected %0b, got %0b", want.stored, rsp_stored);
                  error_count++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("rsp_overflow: expected %0b, got %0b",
                         want.overflow, rsp_overflow);
                  error_count++;
               end
            end
            if (rsp_seen === 1'b1) seen_count++;
            if (rsp_stored === 1'b1) stored_count++;
            if (rsp_overflow === 1'b1) overflow_count++;
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      int phase_start;
      int idle_mix [4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{31, 31}};
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_url_byte = 8'h00;
      req_last     = 1'b0;
      hash_acc     = FNV_BASIS;
      hash_done    = 1'b0;
      log_count    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         drive_item(directed_rows[i].url_byte, directed_rows[i].last,
                    directed_rows[i].typed, directed_rows[i].verdict);
      end

      // mostly fresh urls, a quarter revisits, under each idling mix
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_mix[p][0];
         rsp_stall_pct = idle_mix[p][1];
         phase_start   = byte_items;
         while (byte_items - phase_start < 150) begin
            if ((url_history.size() != 0) && ($urandom_range(3) == 0)) begin
               send_url(old_url());
            end else begin
               send_url(random_url(($urandom_range(9) == 0) ? MAX_URL : 8));
            end
         end
      end
      req_valid <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      // a stray result would follow a full table walk
      repeat (TABLE_DEPTH + 8) @(posedge clock);

      $display("run covered %0d urls in %0d byte items over four idling mixes",
               url_items, byte_items);
      $display("verdicts: %0d seen, %0d stored, %0d overflow; table holds %0d of %0d",
               seen_count, stored_count, overflow_count, log_count, TABLE_DEPTH);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", pending_verdicts.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
